// ===== design/epoch_to_calendar_date_defines.svh =====
// ----------------------------------------------------------------------------
// epoch_to_calendar_date_defines.svh
// Assertion macros shared by the epoch_to_calendar_date checker.
// ----------------------------------------------------------------------------
`ifndef EPOCH_TO_CALENDAR_DATE_DEFINES_SVH
`define EPOCH_TO_CALENDAR_DATE_DEFINES_SVH

// Checked outside reset.
`define E2CD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define E2CD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/e2cd_pkg.sv =====
// ----------------------------------------------------------------------------
// e2cd_pkg
// Types, constants and the month table of the epoch to calendar date block.
// ----------------------------------------------------------------------------
package e2cd_pkg;

    // UTC+8
    localparam logic [32:0] TZ_OFFSET_SEC   = 33'd28800;

    // floor(x/d) = (x * m) >> k for the ranges used here
    localparam logic [31:0] RECIP15_WIDE    = 32'd2290649225;  // k = 35
    localparam logic [25:0] RECIP15_NARROW  = 26'd35791395;    // k = 29
    localparam logic [17:0] RECIP3_WIDE     = 18'd174763;      // k = 19
    localparam logic [17:0] RECIP4383       = 18'd244979;      // k = 30
    localparam logic [16:0] RECIP7          = 17'd74899;       // k = 19
    localparam logic [10:0] RECIP3_NARROW   = 11'd1366;        // k = 12

    localparam logic [20:0] HOURS_PER_BLOCK = 21'd35064;
    localparam logic [15:0] YEAR1_START     = 16'd8760;
    localparam logic [15:0] YEAR2_START     = 16'd17520;
    localparam logic [15:0] YEAR3_START     = 16'd26304;
    localparam logic [1:0]  LEAP_YEAR_SLOT  = 2'd2;
    localparam logic [7:0]  YEAR_BASE       = 8'd70;
    localparam logic [16:0] EPOCH_WEEKDAY   = 17'd4;
    localparam logic [8:0]  FEB29_DAY       = 9'd60;
    localparam logic [3:0]  LAST_MONTH      = 4'd11;

    typedef struct packed {
        logic en;
    } t_pipe_ctl;

    typedef struct packed {
        logic [20:0] hours;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_hour_req;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [7:0] year;
        logic       leap;
        logic [8:0] day_of_year;
    } t_date_req;

    // days before the first of each month, common year
    function automatic logic [8:0] month_start(input logic [3:0] mon);
        logic [8:0] days;
        case (mon)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd59;
            4'd3:    days = 9'd90;
            4'd4:    days = 9'd120;
            4'd5:    days = 9'd151;
            4'd6:    days = 9'd181;
            4'd7:    days = 9'd212;
            4'd8:    days = 9'd243;
            4'd9:    days = 9'd273;
            4'd10:   days = 9'd304;
            4'd11:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

// ===== design/e2cd_time_split.sv =====
// ----------------------------------------------------------------------------
// e2cd_time_split
// Five stages: offset add, then seconds and minutes split off by reciprocal
// multiplication, leaving total local hours.
// ----------------------------------------------------------------------------
module e2cd_time_split (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  e2cd_pkg::t_pipe_ctl  i_ctl,
    input  logic                 i_valid,
    input  logic [31:0]          i_epoch_seconds,
    output logic                 o_valid,
    output e2cd_pkg::t_hour_req  o_req
);
    import e2cd_pkg::*;

    logic [4:0]  r_valid;
    logic [32:0] r_a_t;
    logic [62:0] r_b_p;
    logic [5:0]  r_b_t6;
    logic [26:0] r_c_q;
    logic [5:0]  r_c_sec;
    logic [50:0] r_d_p;
    logic [5:0]  r_d_q6;
    logic [5:0]  r_d_sec;
    logic [20:0] r_e_hours;
    logic [5:0]  r_e_min;
    logic [5:0]  r_e_sec;

    logic [26:0] w_c_q;
    logic [20:0] w_e_hours;

    assign w_c_q     = r_b_p[61:35];
    assign w_e_hours = r_d_p[49:29];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_a_t     <= {1'b0, i_epoch_seconds} + TZ_OFFSET_SEC;
            r_b_p     <= 63'(r_a_t[32:2]) * 63'(RECIP15_WIDE);
            r_b_t6    <= r_a_t[5:0];
            r_c_q     <= w_c_q;
            r_c_sec   <= 6'(r_b_t6 - 6'(w_c_q[5:0] * 6'd60));
            r_d_p     <= 51'(r_c_q[26:2]) * 51'(RECIP15_NARROW);
            r_d_q6    <= r_c_q[5:0];
            r_d_sec   <= r_c_sec;
            r_e_hours <= w_e_hours;
            r_e_min   <= 6'(r_d_q6 - 6'(w_e_hours[5:0] * 6'd60));
            r_e_sec   <= r_d_sec;
        end
    end

    assign o_valid      = r_valid[4];
    assign o_req.hours  = r_e_hours;
    assign o_req.minute = r_e_min;
    assign o_req.second = r_e_sec;

endmodule

// ===== design/e2cd_date_split.sv =====
// ----------------------------------------------------------------------------
// e2cd_date_split
// Five stages: hours to days and four-year blocks, year within the block,
// weekday, day of year and hour of day.
// ----------------------------------------------------------------------------
module e2cd_date_split (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  e2cd_pkg::t_pipe_ctl  i_ctl,
    input  logic                 i_valid,
    input  e2cd_pkg::t_hour_req  i_req,
    output logic                 o_valid,
    output e2cd_pkg::t_date_req  o_req
);
    import e2cd_pkg::*;

    logic [4:0]  r_valid;

    logic [35:0] r_f_pd;
    logic [35:0] r_f_pb;
    logic [20:0] r_f_hours;
    logic [5:0]  r_f_min;
    logic [5:0]  r_f_sec;

    logic [15:0] r_g_days;
    logic [5:0]  r_g_blk;
    logic [15:0] r_g_rem;
    logic [5:0]  r_g_min;
    logic [5:0]  r_g_sec;

    logic [13:0] r_h_remy;
    logic [1:0]  r_h_yoff;
    logic [7:0]  r_h_year;
    logic [31:0] r_h_pw;
    logic [2:0]  r_h_w3;
    logic [5:0]  r_h_min;
    logic [5:0]  r_h_sec;

    logic [21:0] r_i_py;
    logic [4:0]  r_i_rem5;
    logic [2:0]  r_i_wday;
    logic        r_i_leap;
    logic [7:0]  r_i_year;
    logic [5:0]  r_i_min;
    logic [5:0]  r_i_sec;

    t_date_req   r_j_req;

    logic [17:0] w_f_x;
    logic [15:0] w_g_days;
    logic [5:0]  w_g_blk;
    logic [1:0]  w_h_yoff;
    logic [15:0] w_h_start;
    logic [16:0] w_h_w;
    logic [12:0] w_i_q7;
    logic [8:0]  w_j_yday;

    assign w_f_x    = i_req.hours[20:3];
    assign w_g_days = r_f_pd[34:19];
    assign w_g_blk  = r_f_pb[35:30];
    assign w_h_w    = 17'(r_g_days) + EPOCH_WEEKDAY;
    assign w_i_q7   = r_h_pw[31:19];
    assign w_j_yday = r_i_py[20:12];

    always_comb begin
        if (r_g_rem < YEAR1_START) begin
            w_h_yoff  = 2'd0;
            w_h_start = '0;
        end else if (r_g_rem < YEAR2_START) begin
            w_h_yoff  = 2'd1;
            w_h_start = YEAR1_START;
        end else if (r_g_rem < YEAR3_START) begin
            w_h_yoff  = 2'd2;
            w_h_start = YEAR2_START;
        end else begin
            w_h_yoff  = 2'd3;
            w_h_start = YEAR3_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_f_pd    <= 36'(w_f_x) * 36'(RECIP3_WIDE);
            r_f_pb    <= 36'(w_f_x) * 36'(RECIP4383);
            r_f_hours <= i_req.hours;
            r_f_min   <= i_req.minute;
            r_f_sec   <= i_req.second;

            r_g_days  <= w_g_days;
            r_g_blk   <= w_g_blk;
            r_g_rem   <= 16'(r_f_hours - 21'(21'(w_g_blk) * HOURS_PER_BLOCK));
            r_g_min   <= r_f_min;
            r_g_sec   <= r_f_sec;

            r_h_remy  <= 14'(r_g_rem - w_h_start);
            r_h_yoff  <= w_h_yoff;
            r_h_year  <= YEAR_BASE + {r_g_blk, w_h_yoff};
            r_h_pw    <= 32'(w_h_w) * 32'(RECIP7);
            r_h_w3    <= w_h_w[2:0];
            r_h_min   <= r_g_min;
            r_h_sec   <= r_g_sec;

            r_i_py    <= 22'(r_h_remy[13:3]) * 22'(RECIP3_NARROW);
            r_i_rem5  <= r_h_remy[4:0];
            r_i_wday  <= 3'(r_h_w3 - 3'(w_i_q7[2:0] * 3'd7));
            r_i_leap  <= (r_h_yoff == LEAP_YEAR_SLOT);
            r_i_year  <= r_h_year;
            r_i_min   <= r_h_min;
            r_i_sec   <= r_h_sec;

            r_j_req.second      <= r_i_sec;
            r_j_req.minute      <= r_i_min;
            r_j_req.hour        <= 5'(r_i_rem5 - 5'(w_j_yday[4:0] * 5'd24));
            r_j_req.weekday     <= r_i_wday;
            r_j_req.year        <= r_i_year;
            r_j_req.leap        <= r_i_leap;
            r_j_req.day_of_year <= w_j_yday;
        end
    end

    assign o_valid = r_valid[4];
    assign o_req   = r_j_req;

endmodule

// ===== design/e2cd_month.sv =====
// ----------------------------------------------------------------------------
// e2cd_month
// Output stage: month and day of month from day of year, February 29 aside.
// ----------------------------------------------------------------------------
module e2cd_month (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  e2cd_pkg::t_pipe_ctl  i_ctl,
    input  logic                 i_valid,
    input  e2cd_pkg::t_date_req  i_req,
    output logic                 o_valid,
    output logic [5:0]           o_second,
    output logic [5:0]           o_minute,
    output logic [4:0]           o_hour,
    output logic [2:0]           o_weekday,
    output logic [7:0]           o_years_since_1900,
    output logic [3:0]           o_month,
    output logic [4:0]           o_day_of_month,
    output logic [8:0]           o_day_of_year
);
    import e2cd_pkg::*;

    logic       r_valid;
    logic [5:0] r_second;
    logic [5:0] r_minute;
    logic [4:0] r_hour;
    logic [2:0] r_weekday;
    logic [7:0] r_year;
    logic [3:0] r_month;
    logic [4:0] r_mday;
    logic [8:0] r_yday;

    logic [8:0] w_day;
    logic [8:0] w_day_adj;
    logic       w_feb29;
    logic [3:0] w_mon;
    logic [3:0] n_month;
    logic [4:0] n_mday;

    assign w_day     = i_req.day_of_year + 9'd1;
    assign w_feb29   = i_req.leap && (w_day == FEB29_DAY);
    assign w_day_adj = (i_req.leap && (w_day > FEB29_DAY)) ? w_day - 9'd1 : w_day;

    always_comb begin
        w_mon = '0;
        for (int k = 1; k <= int'(LAST_MONTH); k++) begin
            if (w_day_adj > month_start(4'(k))) begin
                w_mon = 4'(k);
            end
        end
    end

    always_comb begin
        if (w_feb29) begin
            n_month = 4'd1;
            n_mday  = 5'd29;
        end else begin
            n_month = w_mon;
            n_mday  = 5'(w_day_adj - month_start(w_mon));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_second  <= i_req.second;
            r_minute  <= i_req.minute;
            r_hour    <= i_req.hour;
            r_weekday <= i_req.weekday;
            r_year    <= i_req.year;
            r_month   <= n_month;
            r_mday    <= n_mday;
            r_yday    <= i_req.day_of_year;
        end
    end

    assign o_valid            = r_valid;
    assign o_second           = r_second;
    assign o_minute           = r_minute;
    assign o_hour             = r_hour;
    assign o_weekday          = r_weekday;
    assign o_years_since_1900 = r_year;
    assign o_month            = r_month;
    assign o_day_of_month     = r_mday;
    assign o_day_of_year      = r_yday;

endmodule

// ===== design/epoch_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// epoch_to_calendar_date
// Unix seconds to broken-down local date and time at UTC+8.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_epoch_seconds. A request is taken
//   on a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with second, minute, hour, weekday,
//   years_since_1900, month, day_of_month and day_of_year. Each request
//   gives exactly one result.
//   Throughput: one request per cycle while not stalled; an 11-stage
//   pipeline of constant reciprocal multipliers and compares.
//   Stall: with o_valid high and i_stall high the whole pipeline holds;
//   o_stall follows, the shown result stays put, and bubbles inside the
//   pipeline are not squeezed out.
//   Reset: synchronous, active low; clears all stage valid bits, so no
//   result is shown after reset. There is no configuration and no state
//   kept between requests.
// ----------------------------------------------------------------------------
module epoch_to_calendar_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [2:0]  o_weekday,
    output logic [7:0]  o_years_since_1900,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [8:0]  o_day_of_year
);
    import e2cd_pkg::*;

    t_pipe_ctl w_ctl;
    logic      w_hour_valid;
    t_hour_req w_hour_req;
    logic      w_date_valid;
    t_date_req w_date_req;

    assign w_ctl.en = !(o_valid && i_stall);
    assign o_stall  = !w_ctl.en;

    e2cd_time_split u_time_split (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .i_valid         (i_valid),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (w_hour_valid),
        .o_req           (w_hour_req)
    );

    e2cd_date_split u_date_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_valid (w_hour_valid),
        .i_req   (w_hour_req),
        .o_valid (w_date_valid),
        .o_req   (w_date_req)
    );

    e2cd_month u_month (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (w_ctl),
        .i_valid            (w_date_valid),
        .i_req              (w_date_req),
        .o_valid            (o_valid),
        .o_second           (o_second),
        .o_minute           (o_minute),
        .o_hour             (o_hour),
        .o_weekday          (o_weekday),
        .o_years_since_1900 (o_years_since_1900),
        .o_month            (o_month),
        .o_day_of_month     (o_day_of_month),
        .o_day_of_year      (o_day_of_year)
    );

endmodule

// ===== design/e2cd_checker.sv =====
// ----------------------------------------------------------------------------
// e2cd_checker
// Port-level checks of epoch_to_calendar_date, bound to the top level.
// ----------------------------------------------------------------------------
`include "epoch_to_calendar_date_defines.svh"

module e2cd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [5:0]  o_second,
    input logic [5:0]  o_minute,
    input logic [4:0]  o_hour,
    input logic [2:0]  o_weekday,
    input logic [7:0]  o_years_since_1900,
    input logic [3:0]  o_month,
    input logic [4:0]  o_day_of_month,
    input logic [8:0]  o_day_of_year
);

    logic [45:0] w_result;
    logic        w_fields_ok;

    assign w_result = {o_second, o_minute, o_hour, o_weekday, o_years_since_1900,
                       o_month, o_day_of_month, o_day_of_year};

    assign w_fields_ok = (o_second < 6'd60) && (o_minute < 6'd60) && (o_hour < 5'd24)
                      && (o_weekday < 3'd7) && (o_month < 4'd12)
                      && (o_day_of_month != 5'd0) && (o_day_of_year < 9'd366);

    `E2CD_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_valid, "result shown right after reset")

    `E2CD_ASSERT(a_stall_follows, o_stall == (o_valid && i_stall), "input stall mismatch")

    `E2CD_ASSERT(a_held_result, o_valid && i_stall |=> o_valid && $stable(w_result), "stalled result changed")

    `E2CD_ASSERT(a_field_range, o_valid |-> w_fields_ok, "result field out of range")

    `E2CD_ASSERT(a_feb_days, o_valid && o_month == 4'd1 |-> o_day_of_month <= 5'd29, "February past day 29")

endmodule

bind epoch_to_calendar_date e2cd_checker u_e2cd_checker (.*);
